// ===== rtl/psc_pkg.sv =====
// Shared types and constants for the point/segment stabbing counter.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package psc_pkg;

    localparam int KIND_W         = 2;
    localparam int RESULT_COUNT_W = 11;

    // Item kinds on the input channel; the remaining code is ignored.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Control bits that travel with a query down the cell chain.
    typedef struct packed {
        logic valid;
        logic ovf;
    } t_qflags;

endpackage

// ===== rtl/psc_if.sv =====
// Channel interfaces of the stabbing counter: item input and result output.
// Depends on psc_pkg.
`timescale 1ns / 1ps

interface psc_item_if #(
    parameter int COORD_WIDTH = 32
);
    import psc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [KIND_W-1:0]             kind;
    logic signed [COORD_WIDTH-1:0] seg_start_coord;
    logic signed [COORD_WIDTH-1:0] seg_end_coord;
    logic signed [COORD_WIDTH-1:0] point_coord;

    modport source (
        output valid, kind, seg_start_coord, seg_end_coord, point_coord,
        input  ready
    );
    modport sink (
        input  valid, kind, seg_start_coord, seg_end_coord, point_coord,
        output ready
    );
endinterface

interface psc_result_if;
    import psc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [RESULT_COUNT_W-1:0] containing_count;
    logic                      table_overflowed;

    modport source (
        output valid, containing_count, table_overflowed,
        input  ready
    );
    modport sink (
        input  valid, containing_count, table_overflowed,
        output ready
    );
endinterface

// ===== rtl/psc_cell.sv =====
// One cell of the segment chain: holds one segment as order-preserving keys,
// tests the passing query against it and hands the partial count on. Uses psc_pkg.
`timescale 1ns / 1ps

module psc_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int CNT_W       = 11,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_wr_en,
    input  logic [CNT_W-1:0]       i_wr_idx,
    input  logic [COORD_WIDTH-1:0] i_wr_start,
    input  logic [COORD_WIDTH-1:0] i_wr_end,
    input  psc_pkg::t_qflags       i_flags,
    input  logic [COORD_WIDTH-1:0] i_point,
    input  logic [CNT_W-1:0]       i_hits,
    input  logic [CNT_W-1:0]       i_snap,
    output psc_pkg::t_qflags       o_flags,
    output logic [COORD_WIDTH-1:0] o_point,
    output logic [CNT_W-1:0]       o_hits,
    output logic [CNT_W-1:0]       o_snap
);
    import psc_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [COORD_WIDTH-1:0] r_start;
    logic [COORD_WIDTH-1:0] r_end;
    t_qflags                r_flags;
    logic [COORD_WIDTH-1:0] r_point;
    logic [CNT_W-1:0]       r_hits;
    logic [CNT_W-1:0]       r_snap;

    logic             w_hit;
    logic [CNT_W-1:0] n_hits;

    // Count only slots that were filled when the query was issued.
    assign w_hit  = i_flags.valid && (MY_IDX < i_snap)
                    && (r_start <= i_point) && (i_point <= r_end);
    assign n_hits = i_hits + CNT_W'(w_hit);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_start <= i_wr_start;
            r_end   <= i_wr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_adv) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_point <= i_point;
            r_hits  <= n_hits;
            r_snap  <= i_snap;
        end
    end

    assign o_flags = r_flags;
    assign o_point = r_point;
    assign o_hits  = r_hits;
    assign o_snap  = r_snap;

endmodule

// ===== rtl/point_segment_stabbing_count_top.sv =====
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------------------
// i_item    | in  | kind, seg_start_coord, seg_end_coord, point_coord
// o_result  | out | containing_count, table_overflowed (only for a query)
//
// One input beat is taken per cycle while the result register is free or being
// drained; clear and add take effect at once. A query walks the chain of
// MAX_SEGMENTS cells, one cell per cycle while the chain advances, and then
// enters the result register. Reset is synchronous, active low, and empties the
// table without touching the stored segments. A stalled result freezes the whole
// chain and holds i_item.ready low. Depends on psc_pkg, psc_if, psc_cell.
`timescale 1ns / 1ps

module point_segment_stabbing_count_top #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int COORD_WIDTH  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psc_item_if.sink       i_item,
    psc_result_if.source   o_result
);
    import psc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_SEGMENTS);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;

    logic                      r_out_valid;
    logic [RESULT_COUNT_W-1:0] r_out_count;
    logic                      r_out_ovf;

    logic w_adv;
    logic w_accept;
    logic w_wr_en;

    logic [COORD_WIDTH-1:0] w_start_key;
    logic [COORD_WIDTH-1:0] w_end_key;

    t_qflags                w_flags [0:MAX_SEGMENTS];
    logic [COORD_WIDTH-1:0] w_point [0:MAX_SEGMENTS];
    logic [CNT_W-1:0]       w_hits  [0:MAX_SEGMENTS];
    logic [CNT_W-1:0]       w_snap  [0:MAX_SEGMENTS];

    assign w_adv        = !r_out_valid || o_result.ready;
    assign i_item.ready = w_adv;
    assign w_accept     = i_item.valid && w_adv;

    // Flip the sign bit so that unsigned compares order signed coordinates.
    assign w_start_key = {~i_item.seg_start_coord[COORD_WIDTH-1],
                          i_item.seg_start_coord[COORD_WIDTH-2:0]};
    assign w_end_key   = {~i_item.seg_end_coord[COORD_WIDTH-1],
                          i_item.seg_end_coord[COORD_WIDTH-2:0]};

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        w_wr_en = 1'b0;
        if (w_accept) begin
            case (i_item.kind)
                KIND_CLEAR: begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
                KIND_ADD: begin
                    if (r_count < CAPACITY) begin
                        w_wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // A query carries the fill level and drop flag seen at issue.
    assign w_flags[0].valid = w_accept && (i_item.kind == KIND_QUERY);
    assign w_flags[0].ovf   = r_ovf;
    assign w_point[0]       = {~i_item.point_coord[COORD_WIDTH-1],
                               i_item.point_coord[COORD_WIDTH-2:0]};
    assign w_hits[0]        = '0;
    assign w_snap[0]        = r_count;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        psc_cell #(
            .COORD_WIDTH(COORD_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_wr_en   (w_wr_en),
            .i_wr_idx  (r_count),
            .i_wr_start(w_start_key),
            .i_wr_end  (w_end_key),
            .i_flags   (w_flags[g]),
            .i_point   (w_point[g]),
            .i_hits    (w_hits[g]),
            .i_snap    (w_snap[g]),
            .o_flags   (w_flags[g+1]),
            .o_point   (w_point[g+1]),
            .o_hits    (w_hits[g+1]),
            .o_snap    (w_snap[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_flags[MAX_SEGMENTS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_count <= RESULT_COUNT_W'(w_hits[MAX_SEGMENTS]);
            r_out_ovf   <= w_flags[MAX_SEGMENTS].ovf;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.containing_count = r_out_count;
    assign o_result.table_overflowed = r_out_ovf;

endmodule

// ===== rtl/psc_chk.sv =====
// Port-level checks for the stabbing counter, bound to the top level.
// Depends on psc_pkg and point_segment_stabbing_count_top.
`timescale 1ns / 1ps

module psc_chk #(
    parameter int MAX_SEGMENTS = 1024
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [psc_pkg::RESULT_COUNT_W-1:0] i_out_count,
    input logic                               i_out_ovf
);
    import psc_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_count) && $stable(i_out_ovf))
        else $error("result beat changed while stalled");

    // A stalled result must block new input.
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while result stalled");

    // Drop any pending result on reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A count never exceeds the table size; checked only for tables of up to 2047 slots.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_SEGMENTS > 2047) || (32'(i_out_count) <= MAX_SEGMENTS))
        else $error("count above table size");

endmodule

bind point_segment_stabbing_count_top psc_chk #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
) u_psc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_count(o_result.containing_count),
    .i_out_ovf  (o_result.table_overflowed)
);
